@@ rtl/psa_pkg.sv @@
`timescale 1ns / 1ps

package psa_pkg;

  localparam int SUB_DEF        = 4;
  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;

  localparam int ORDER_DEPTH = 256;

  localparam logic [1:0] OP_DEPOSIT = 2'd0;
  localparam logic [1:0] OP_END     = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;
  localparam logic [1:0] OP_RESTART = 2'd3;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam logic [9:0] EXTENT_RESET = 10'd512;

  typedef logic [ORDER_DEPTH-1:0][3:0] order_t;

  // index of the highest set bit, zero for a zero word
  function automatic logic [4:0] msb_pos(input logic [16:0] v);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 17; i++) begin
      if (v[i]) begin
        p = 5'(i);
      end
    end
    return p;
  endfunction

  // sub-pixel visiting order, column or row part
  function automatic order_t gen_order(input int sub, input bit want_y);
    order_t tab;
    int x;
    int y;
    int step;
    bit odd;
    tab = '0;
    x = 0;
    y = 0;
    step = 2 * sub;
    odd = 1'b1;
    for (int i = 0; i < sub * sub; i++) begin
      tab[i] = want_y ? 4'(y & 15) : 4'(x & 15);
      x = x + (odd ? step : step / 2);
      if (x >= sub) begin
        y = y + step / 2;
        if (y >= sub) begin
          step = step / 2;
          y = 0;
          x = step / 2;
          odd = 1'b1;
        end else begin
          odd = !odd;
          x = odd ? step / 2 : 0;
        end
      end
    end
    return tab;
  endfunction

endpackage

@@ rtl/progressive_sample_accumulator_core.sv @@
`timescale 1ns / 1ps

// one item at a time, busy high from the accepted start until the result strobe
// end of pass, restart and off-screen read go straight to the strobe; a deposit fills
//   a fill-edge square (SUB on the first pass) or blends by read, multiply and divide
// read: cell alignment, reads of each pixel of the cell, averaging, then the strobe
// reset clears the pass count and sets the extent to 512 by 512; the pixel store keeps
//   its contents; results cannot be stalled, each done strobe lasts one cycle
module progressive_sample_accumulator_core #(
  parameter int SUB        = psa_pkg::SUB_DEF,
  parameter int MAX_WIDTH  = psa_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = psa_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [8:0]  pos_x,
  input  logic [8:0]  pos_y,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_data,
  output logic        done,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic [15:0] pass_count,
  output logic        refining,
  output logic [4:0]  cell_size
);

  localparam int SQ    = SUB * SUB;
  localparam int KW    = $clog2(SQ);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  // wide enough for coarse position times SUB plus offsets and both extents
  localparam int CW    = $clog2(512 * SUB + 2 * SUB + MAX_WIDTH + MAX_HEIGHT + 1);

  localparam psa_pkg::order_t ORD_X = psa_pkg::gen_order(SUB, 1'b0);
  localparam psa_pkg::order_t ORD_Y = psa_pkg::gen_order(SUB, 1'b1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_FILL  = 11'b00000000010,
    S_BRD   = 11'b00000000100,
    S_BMUL  = 11'b00000001000,
    S_BDIV  = 11'b00000010000,
    S_ALIGN = 11'b00000100000,
    S_RLOOP = 11'b00001000000,
    S_RDRN  = 11'b00010000000,
    S_RDIV  = 11'b00100000000,
    S_FIN   = 11'b01000000000,
    S_SPARE = 11'b10000000000
  } state_t;

  state_t state;

  // configuration
  logic [9:0] sw;
  logic [9:0] sh;

  // pass tracking: pc, pc mod SQ and pc / SQ
  logic [15:0]   pc;
  logic [KW-1:0] kk;
  logic [15:0]   qq;

  // working registers
  logic [CW-1:0] bx;
  logic [CW-1:0] by;
  logic [4:0]    io;
  logic [4:0]    jo;
  logic [4:0]    edge_len;
  logic [7:0]    col_r;
  logic [7:0]    col_g;
  logic [7:0]    col_b;
  logic [15:0]   wp;
  logic [8:0]    px;
  logic [8:0]    py;
  logic          rv;
  logic [15:0]   sum_r;
  logic [15:0]   sum_g;
  logic [15:0]   sum_b;
  logic [8:0]    npix;
  logic [7:0]    res_r;
  logic [7:0]    res_g;
  logic [7:0]    res_b;

  // derived values
  logic [CW-1:0] aw;
  logic [CW-1:0] ah;
  logic [CW-1:0] cx;
  logic [CW-1:0] cy;
  logic          in_ext;
  logic [AW-1:0] ram_addr;
  logic          ram_we;
  logic [23:0]   ram_wdata;
  logic [23:0]   ram_rdata;
  logic [4:0]    k_cell;
  logic [4:0]    k_fill;
  logic [4:0]    cs_raw;
  logic [4:0]    cs;
  logic [4:0]    fill_raw;
  logic [4:0]    fill;
  logic [CW-1:0] dep_x;
  logic [CW-1:0] dep_y;
  logic          last_cell;
  logic          inner_last;
  logic [15:0]   sum_r_next;
  logic [15:0]   sum_g_next;
  logic [15:0]   sum_b_next;
  logic [8:0]    npix_next;

  // dividers
  logic          ch_start;
  logic [23:0]   num_r;
  logic [23:0]   num_g;
  logic [23:0]   num_b;
  logic [16:0]   ch_den;
  logic          dr_done;
  logic          dg_done;
  logic          db_done;
  logic [7:0]    q_r;
  logic [7:0]    q_g;
  logic [7:0]    q_b;
  logic          al_start;
  logic          ax_done;
  logic          ay_done;
  logic [8:0]    ax_quo;
  logic [8:0]    ay_quo;
  logic [8:0]    ax_rem;
  logic [8:0]    ay_rem;

  logic accept;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // active extent, clipped to the store
  assign aw = (CW'(sw) > CW'(MAX_WIDTH))  ? CW'(MAX_WIDTH)  : CW'(sw);
  assign ah = (CW'(sh) > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : CW'(sh);

  // display cell edge from pc + 1, fill edge from pc
  assign k_cell   = psa_pkg::msb_pos(17'(pc) + 17'd1) >> 1;
  assign k_fill   = psa_pkg::msb_pos(17'(pc)) >> 1;
  assign cs_raw   = 5'(SUB) >> k_cell;
  assign cs       = (cs_raw == 5'd0) ? 5'd1 : cs_raw;
  assign fill_raw = 5'(SUB / 2) >> k_fill;
  assign fill     = (pc == 16'd0) ? 5'(SUB) : ((fill_raw == 5'd0) ? 5'd1 : fill_raw);

  // deposit target pixel
  assign dep_x = CW'(CW'(pos_x) * CW'(SUB) + CW'(ORD_X[8'(kk)]));
  assign dep_y = CW'(CW'(pos_y) * CW'(SUB) + CW'(ORD_Y[8'(kk)]));

  // current pixel of a sweep; blend keeps the offsets at zero
  assign cx        = bx + CW'(io);
  assign cy        = by + CW'(jo);
  assign in_ext    = (cx < aw) && (cy < ah);
  assign ram_addr  = AW'(AW'(cy) * AW'(MAX_WIDTH) + AW'(cx));
  assign inner_last = (jo == edge_len - 5'd1);
  assign last_cell = inner_last && (io == edge_len - 5'd1);

  assign ram_we    = ((state == S_FILL) && in_ext) || ((state == S_BDIV) && dr_done);
  assign ram_wdata = (state == S_FILL) ? {col_r, col_g, col_b} : {q_r, q_g, q_b};

  // cell accumulation, in the cycle after the read
  assign sum_r_next = rv ? sum_r + 16'(ram_rdata[23:16]) : sum_r;
  assign sum_g_next = rv ? sum_g + 16'(ram_rdata[15:8])  : sum_g;
  assign sum_b_next = rv ? sum_b + 16'(ram_rdata[7:0])   : sum_b;
  assign npix_next  = rv ? npix + 9'd1 : npix;

  // channel dividers: running average for a blend, cell mean for a read
  assign ch_start = (state == S_BMUL) || (state == S_RDRN);
  always_comb begin
    if (state == S_BMUL) begin
      num_r  = 24'(ram_rdata[23:16]) * 24'(wp) + 24'(col_r);
      num_g  = 24'(ram_rdata[15:8]) * 24'(wp) + 24'(col_g);
      num_b  = 24'(ram_rdata[7:0]) * 24'(wp) + 24'(col_b);
      ch_den = 17'(wp) + 17'd1;
    end else begin
      num_r  = 24'(sum_r_next);
      num_g  = 24'(sum_g_next);
      num_b  = 24'(sum_b_next);
      ch_den = 17'(npix_next);
    end
  end

  assign al_start = accept && (opcode == psa_pkg::OP_READ);

  psa_ram #(
    .WIDTH (24),
    .DEPTH (DEPTH),
    .ADDR_W(AW)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  psa_div #(.NW(24), .DW(17), .QW(8)) u_div_r (
    .clk(clk), .rst(rst), .start(ch_start), .num(num_r), .den(ch_den),
    .done(dr_done), .quo(q_r), .rem()
  );

  psa_div #(.NW(24), .DW(17), .QW(8)) u_div_g (
    .clk(clk), .rst(rst), .start(ch_start), .num(num_g), .den(ch_den),
    .done(dg_done), .quo(q_g), .rem()
  );

  psa_div #(.NW(24), .DW(17), .QW(8)) u_div_b (
    .clk(clk), .rst(rst), .start(ch_start), .num(num_b), .den(ch_den),
    .done(db_done), .quo(q_b), .rem()
  );

  // cell alignment: remainder of the pixel position by the cell edge
  psa_div #(.NW(9), .DW(5), .QW(9)) u_align_x (
    .clk(clk), .rst(rst), .start(al_start), .num(pos_x), .den(cs),
    .done(ax_done), .quo(ax_quo), .rem(ax_rem)
  );

  psa_div #(.NW(9), .DW(5), .QW(9)) u_align_y (
    .clk(clk), .rst(rst), .start(al_start), .num(pos_y), .den(cs),
    .done(ay_done), .quo(ay_quo), .rem(ay_rem)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sw <= psa_pkg::EXTENT_RESET;
      sh <= psa_pkg::EXTENT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        psa_pkg::CFG_WIDTH:  sw <= cfg_data;
        psa_pkg::CFG_HEIGHT: sh <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= '0;
      kk    <= '0;
      qq    <= '0;
      done  <= 1'b0;
      rv    <= 1'b0;
    end else begin
      done <= (state == S_FIN);
      case (state)
        S_IDLE: begin
          rv <= 1'b0;
          if (accept) begin
            case (opcode)
              psa_pkg::OP_DEPOSIT: begin
                if (qq == 16'd0) begin
                  state <= S_FILL;
                end else begin
                  state <= S_BRD;
                end
              end
              psa_pkg::OP_END: begin
                if (pc != 16'hffff) begin
                  pc <= pc + 16'd1;
                  if (kk == KW'(SQ - 1)) begin
                    kk <= '0;
                    qq <= qq + 16'd1;
                  end else begin
                    kk <= kk + 1'b1;
                  end
                end
                state <= S_FIN;
              end
              psa_pkg::OP_READ: begin
                if ((CW'(pos_x) >= aw) || (CW'(pos_y) >= ah)) begin
                  state <= S_FIN;
                end else begin
                  state <= S_ALIGN;
                end
              end
              default: begin
                pc    <= '0;
                kk    <= '0;
                qq    <= '0;
                state <= S_FIN;
              end
            endcase
          end
        end
        S_FILL: begin
          if (last_cell) begin
            state <= S_FIN;
          end
        end
        S_BRD: begin
          // a blend target off the active extent is dropped
          state <= in_ext ? S_BMUL : S_FIN;
        end
        S_BMUL: begin
          state <= S_BDIV;
        end
        S_BDIV: begin
          if (dr_done && dg_done && db_done) begin
            state <= S_FIN;
          end
        end
        S_ALIGN: begin
          if (ax_done && ay_done && (ax_quo[0] || !ax_quo[0]) && (ay_quo == ay_quo)) begin
            state <= S_RLOOP;
          end
        end
        S_RLOOP: begin
          rv <= in_ext;
          if (last_cell) begin
            state <= S_RDRN;
          end
        end
        S_RDRN: begin
          rv    <= 1'b0;
          state <= S_RDIV;
        end
        S_RDIV: begin
          if (dr_done && dg_done && db_done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          col_r    <= red_in;
          col_g    <= green_in;
          col_b    <= blue_in;
          px       <= pos_x;
          py       <= pos_y;
          bx       <= dep_x;
          by       <= dep_y;
          io       <= 5'd0;
          jo       <= 5'd0;
          edge_len <= fill;
          wp       <= qq + ((kk == KW'(SQ - 1)) ? 16'd1 : 16'd0);
          res_r    <= 8'd0;
          res_g    <= 8'd0;
          res_b    <= 8'd0;
        end
      end
      S_FILL, S_RLOOP: begin
        if (inner_last) begin
          jo <= 5'd0;
          io <= io + 5'd1;
        end else begin
          jo <= jo + 5'd1;
        end
        sum_r <= sum_r_next;
        sum_g <= sum_g_next;
        sum_b <= sum_b_next;
        npix  <= npix_next;
      end
      S_ALIGN: begin
        bx       <= CW'(px - ax_rem);
        by       <= CW'(py - ay_rem);
        io       <= 5'd0;
        jo       <= 5'd0;
        edge_len <= cs;
        sum_r    <= 16'd0;
        sum_g    <= 16'd0;
        sum_b    <= 16'd0;
        npix     <= 9'd0;
      end
      S_RDIV: begin
        res_r <= q_r;
        res_g <= q_g;
        res_b <= q_b;
      end
      default: ;
    endcase
  end

  // result registers, loaded together with done and held until the next result
  always_ff @(posedge clk) begin
    if (state == S_FIN) begin
      red_out    <= res_r;
      green_out  <= res_g;
      blue_out   <= res_b;
      pass_count <= pc;
      refining   <= (qq != 16'd0);
      cell_size  <= cs;
    end
  end

endmodule

@@ rtl/psa_ram.sv @@
`timescale 1ns / 1ps

module psa_ram #(
  parameter int WIDTH  = 24,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/psa_div.sv @@
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle, quotient known to fit in QW bits
module psa_div #(
  parameter int NW = 24,
  parameter int DW = 17,
  parameter int QW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [QW-1:0] quo,
  output logic [NW-1:0] rem
);

  localparam int MW = (NW > DW + QW) ? NW : DW + QW;
  localparam int CW = $clog2(QW + 1);

  logic [MW-1:0] dsh;
  logic [CW-1:0] cnt;
  logic          take;

  assign take = MW'(rem) >= dsh;
  assign done = (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(QW);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsh <= MW'(den) << (QW - 1);
      quo <= '0;
    end else if (cnt != '0) begin
      if (take) begin
        rem <= NW'(MW'(rem) - dsh);
      end
      quo <= {quo[QW-2:0], take};
      dsh <= dsh >> 1;
    end
  end

endmodule
